FILE: design/c2p_pkg.sv
package c2p_pkg;

  // CORDIC datapath width: holds +/-2^31 after pre-rotation plus the CORDIC gain
  localparam int CW = 36;
  localparam int SQRT_BITS = 32;
  localparam int DIV_BITS = 32;

  // pi in Q2.30
  localparam logic signed [CW-1:0] ANG_PI = 36'sd3373259426;
  // range rate saturation magnitude
  localparam logic [31:0] RATE_LIMIT = 32'd3037000499;

  // atan(2^-i) in Q2.30 for the first ten steps
  localparam logic [31:0] ATAN_HEAD [10] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
  };

  typedef logic signed [CW-1:0] cval_t;

  // one CORDIC vector: x, y and the angle accumulator
  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cvec_t;

  // side data that travels along the range rate path
  typedef struct packed {
    logic [63:0] dm;
    logic        neg;
    logic        still;
    logic [31:0] rng;
    logic [31:0] spd;
    logic        zero;
    logic        ovf;
  } carry_t;

  // step angle of CORDIC iteration i
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] res;
    if (i < 10) begin
      res = ATAN_HEAD[i[3:0]];
    end else if (i <= 30) begin
      res = 32'd1 << (30 - i);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] res;
    res = v[31] ? (~v + 32'd1) : v;
    return res;
  endfunction

  // fold the left half plane onto the right one, seeding the angle with +/-pi
  function automatic cvec_t cordic_init(input logic signed [31:0] xi,
                                        input logic signed [31:0] yi);
    cvec_t c;
    c.x = cval_t'(xi);
    c.y = cval_t'(yi);
    c.z = '0;
    if (xi[31]) begin
      c.z = yi[31] ? -ANG_PI : ANG_PI;
      c.x = -c.x;
      c.y = -c.y;
    end
    return c;
  endfunction

endpackage

FILE: design/c2p_cordic_cell.sv
module c2p_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  c2p_pkg::cvec_t vin,
  output c2p_pkg::cvec_t vout
);
  import c2p_pkg::*;

  localparam cval_t STEP = cval_t'(atan_q30(IDX));

  cval_t dx, dy;

  assign dx = vin.y >>> IDX;
  assign dy = vin.x >>> IDX;

  // one vectoring micro-rotation; a zero y means the angle is final
  always_ff @(posedge clk) begin
    if (en) begin
      if (vin.y == '0) begin
        vout <= vin;
      end else if (!vin.y[CW-1]) begin
        vout.x <= vin.x + dx;
        vout.y <= vin.y - dy;
        vout.z <= vin.z + STEP;
      end else begin
        vout.x <= vin.x - dx;
        vout.y <= vin.y + dy;
        vout.z <= vin.z - STEP;
      end
    end
  end

endmodule

FILE: design/c2p_sqrt_cell.sv
module c2p_sqrt_cell #(
  parameter int BIT = 31
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] rem_out,
  output logic [31:0] root_out
);

  logic [64:0] trial;

  // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
  assign trial = ({33'd0, root_in} << (BIT + 1)) + (65'd1 << (2 * BIT));

  // decide one root bit
  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_out  <= rem_in - trial[63:0];
        root_out <= root_in | (32'd1 << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

FILE: design/c2p_div_cell.sv
module c2p_div_cell #(
  parameter int BIT = 31
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] rem_in,
  input  logic [31:0] q_in,
  input  logic [31:0] divisor,
  input  logic        dbit,
  output logic [31:0] rem_out,
  output logic [31:0] q_out
);

  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_in, dbit};
  assign diff    = shifted - {1'b0, divisor};

  // one restoring division step
  always_ff @(posedge clk) begin
    if (en) begin
      if (shifted >= {1'b0, divisor}) begin
        rem_out <= diff[31:0];
        q_out   <= q_in | (32'd1 << BIT);
      end else begin
        rem_out <= shifted[31:0];
        q_out   <= q_in;
      end
    end
  end

endmodule

FILE: design/cartesian_to_polar_radar_unit.sv
// Radar measurement of a constant-velocity state.
// Input channel (in_valid/in_ready): one state pos_x, pos_y, vel_x, vel_y in
// signed Q16.16 per transfer. Output channel (out_valid/out_ready): range,
// bearing, range rate, speed, heading and the zero-speed flag of that state.
// min_range is written through min_range_we/min_range_data only while idle;
// the user must keep to this, the block itself does not enforce it.
// The datapath is a row of 70 register stages: input register, magnitudes,
// 32x32 products, sums, 32 square root cells (range and speed side by side),
// clamp, 32 restoring divider cells and a saturation/output stage. The CORDIC
// cells for bearing and heading run alongside and wait in a delay line.
// Throughput: one state per cycle while out_ready is high; every stage holds one item.
// Stall: each stage loads when it is empty or its successor moves, so bubbles
// close up and inputs keep being taken while a result waits, until the row
// is full; then in_ready drops. Nothing is lost while out_ready is low.
// Reset clears all stage valid bits and sets min_range to 7.
module cartesian_to_polar_radar_unit #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       min_range_we,
  input  logic [15:0]                min_range_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         pos_x,
  input  logic signed [31:0]         pos_y,
  input  logic signed [31:0]         vel_x,
  input  logic signed [31:0]         vel_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                range_out,
  output logic signed [FRAC_BITS+2:0] bearing_out,
  output logic signed [32:0]         range_rate_out,
  output logic [31:0]                speed_out,
  output logic [FRAC_BITS+1:0]       heading_out,
  output logic                       speed_zero
);
  import c2p_pkg::*;

  localparam int ST_MAG   = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_SQ0   = 4;
  localparam int ST_CLAMP = ST_SQ0 + SQRT_BITS;
  localparam int ST_DV0   = ST_CLAMP + 1;
  localparam int LAST     = ST_DV0 + DIV_BITS;
  localparam int ST_ROUND = ST_MUL + CORDIC_ITERATIONS;
  localparam int SH       = 30 - FRAC_BITS;
  localparam int BW       = FRAC_BITS + 3;
  localparam int HW       = FRAC_BITS + 2;
  localparam cval_t HALF  = cval_t'(36'd1 << (SH - 1));
  localparam cval_t LIM   = (ANG_PI + HALF) >>> SH;

  typedef struct packed {
    logic signed [BW-1:0] brg;
    logic [HW-1:0]        hdg;
  } ang_t;

  logic [LAST:0] v;
  logic [LAST:0] en;
  logic [15:0]   min_range;

  logic signed [31:0] px_q, py_q, vx_q, vy_q;
  logic [31:0] apx, apy, avx, avy;
  logic        n1_a, n2_a, still_a, n1_b, n2_b, still_b;
  logic [63:0] sq_px, sq_py, sq_vx, sq_vy, t1, t2;

  cvec_t       cb [CORDIC_ITERATIONS+1];
  cvec_t       ch [CORDIC_ITERATIONS+1];
  logic [63:0] rrem  [SQRT_BITS+1];
  logic [31:0] rroot [SQRT_BITS+1];
  logic [63:0] srem  [SQRT_BITS+1];
  logic [31:0] sroot [SQRT_BITS+1];
  logic [31:0] dv_rem [DIV_BITS+1];
  logic [31:0] dv_q   [DIV_BITS+1];
  carry_t      car [ST_SUM:LAST-1];
  ang_t        ang [ST_ROUND:LAST-1];

  logic [31:0] rng_clamped;
  cval_t       rb, rh, rb_c, rh_c, rh_abs;
  logic [31:0] q_sat;
  carry_t      cf;

  // stage control: a stage loads when empty or when its successor moves
  assign en[LAST] = !v[LAST] || out_ready;
  genvar k;
  generate
    for (k = 0; k < LAST; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= 16'd7;
    end else if (min_range_we) begin
      min_range <= min_range_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_q <= pos_x;
      py_q <= pos_y;
      vx_q <= vel_x;
      vy_q <= vel_y;
    end
  end

  // magnitudes, sign relations, CORDIC pre-rotation
  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      apx     <= mag32(px_q);
      apy     <= mag32(py_q);
      avx     <= mag32(vx_q);
      avy     <= mag32(vy_q);
      n1_a    <= px_q[31] ^ vx_q[31];
      n2_a    <= py_q[31] ^ vy_q[31];
      still_a <= (vx_q == '0) && (vy_q == '0);
      cb[0]   <= cordic_init(px_q, py_q);
      ch[0]   <= cordic_init(vx_q, vy_q);
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      sq_px   <= 64'(apx) * 64'(apx);
      sq_py   <= 64'(apy) * 64'(apy);
      sq_vx   <= 64'(avx) * 64'(avx);
      sq_vy   <= 64'(avy) * 64'(avy);
      t1      <= 64'(apx) * 64'(avx);
      t2      <= 64'(apy) * 64'(avy);
      n1_b    <= n1_a;
      n2_b    <= n2_a;
      still_b <= still_a;
    end
  end

  // sums of squares and the signed dot product as sign and magnitude
  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      rrem[0]           <= sq_px + sq_py;
      srem[0]           <= sq_vx + sq_vy;
      car[ST_SUM].rng   <= '0;
      car[ST_SUM].spd   <= '0;
      car[ST_SUM].zero  <= 1'b0;
      car[ST_SUM].ovf   <= 1'b0;
      car[ST_SUM].still <= still_b;
      if (n1_b == n2_b) begin
        car[ST_SUM].dm  <= t1 + t2;
        car[ST_SUM].neg <= n1_b;
      end else if (t1 >= t2) begin
        car[ST_SUM].dm  <= t1 - t2;
        car[ST_SUM].neg <= n1_b;
      end else begin
        car[ST_SUM].dm  <= t2 - t1;
        car[ST_SUM].neg <= n2_b;
      end
    end
  end

  assign rroot[0] = '0;
  assign sroot[0] = '0;

  // square root cells, one root bit each, range and speed in parallel
  generate
    for (k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      c2p_sqrt_cell #(.BIT(SQRT_BITS - 1 - k)) u_rng (
        .clk     (clk),
        .en      (en[ST_SQ0+k]),
        .rem_in  (rrem[k]),
        .root_in (rroot[k]),
        .rem_out (rrem[k+1]),
        .root_out(rroot[k+1])
      );
      c2p_sqrt_cell #(.BIT(SQRT_BITS - 1 - k)) u_spd (
        .clk     (clk),
        .en      (en[ST_SQ0+k]),
        .rem_in  (srem[k]),
        .root_in (sroot[k]),
        .rem_out (srem[k+1]),
        .root_out(sroot[k+1])
      );
      always_ff @(posedge clk) begin
        if (en[ST_SQ0+k]) begin
          car[ST_SQ0+k] <= car[ST_SQ0+k-1];
        end
      end
    end
  endgenerate

  // range clamp and divider qualification
  assign rng_clamped = (rroot[SQRT_BITS] < {16'd0, min_range}) ?
                       {16'd0, min_range} : rroot[SQRT_BITS];

  always_ff @(posedge clk) begin
    if (en[ST_CLAMP]) begin
      car[ST_CLAMP].dm    <= car[ST_CLAMP-1].dm;
      car[ST_CLAMP].neg   <= car[ST_CLAMP-1].neg;
      car[ST_CLAMP].still <= car[ST_CLAMP-1].still;
      car[ST_CLAMP].rng   <= rng_clamped;
      car[ST_CLAMP].spd   <= sroot[SQRT_BITS];
      car[ST_CLAMP].zero  <= (rng_clamped == '0);
      car[ST_CLAMP].ovf   <= (car[ST_CLAMP-1].dm[63:32] >= rng_clamped);
    end
  end

  assign dv_rem[0] = car[ST_CLAMP].dm[63:32];
  assign dv_q[0]   = '0;

  // divider cells, one quotient bit each
  generate
    for (k = 0; k < DIV_BITS; k++) begin : g_div
      c2p_div_cell #(.BIT(DIV_BITS - 1 - k)) u_div (
        .clk    (clk),
        .en     (en[ST_DV0+k]),
        .rem_in (dv_rem[k]),
        .q_in   (dv_q[k]),
        .divisor(car[ST_DV0+k-1].rng),
        .dbit   (car[ST_DV0+k-1].dm[DIV_BITS-1-k]),
        .rem_out(dv_rem[k+1]),
        .q_out  (dv_q[k+1])
      );
      if (ST_DV0 + k < LAST) begin : g_car
        always_ff @(posedge clk) begin
          if (en[ST_DV0+k]) begin
            car[ST_DV0+k] <= car[ST_DV0+k-1];
          end
        end
      end
    end
  endgenerate

  // CORDIC cells for bearing and heading
  generate
    for (k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cordic
      c2p_cordic_cell #(.IDX(k)) u_brg (
        .clk (clk),
        .en  (en[ST_MUL+k]),
        .vin (cb[k]),
        .vout(cb[k+1])
      );
      c2p_cordic_cell #(.IDX(k)) u_hdg (
        .clk (clk),
        .en  (en[ST_MUL+k]),
        .vin (ch[k]),
        .vout(ch[k+1])
      );
    end
  endgenerate

  // angle rounding to FRAC_BITS, ties upward, clamped to +/- pi
  assign rb   = (cb[CORDIC_ITERATIONS].z + HALF) >>> SH;
  assign rh   = (ch[CORDIC_ITERATIONS].z + HALF) >>> SH;
  assign rb_c = (rb > LIM) ? LIM : ((rb < -LIM) ? -LIM : rb);
  assign rh_c = (rh > LIM) ? LIM : ((rh < -LIM) ? -LIM : rh);
  assign rh_abs = rh_c[CW-1] ? -rh_c : rh_c;

  always_ff @(posedge clk) begin
    if (en[ST_ROUND]) begin
      ang[ST_ROUND].brg <= rb_c[BW-1:0];
      ang[ST_ROUND].hdg <= car[ST_ROUND-1].still ? '0 : rh_abs[HW-1:0];
    end
  end

  // angle delay line up to the output stage
  generate
    for (k = ST_ROUND + 1; k < LAST; k++) begin : g_ang
      always_ff @(posedge clk) begin
        if (en[k]) begin
          ang[k] <= ang[k-1];
        end
      end
    end
  endgenerate

  // saturation, sign and output register
  assign cf    = car[LAST-1];
  assign q_sat = cf.zero ? '0 :
                 (cf.ovf || (dv_q[DIV_BITS] > RATE_LIMIT)) ? RATE_LIMIT :
                 dv_q[DIV_BITS];

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      range_out      <= cf.rng;
      speed_out      <= cf.spd;
      speed_zero     <= cf.still;
      range_rate_out <= cf.neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      bearing_out    <= ang[LAST-1].brg;
      heading_out    <= ang[LAST-1].hdg;
    end
  end

endmodule

FILE: design/c2p_checker.sv
module c2p_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [31:0]          range_out,
  input logic [31:0]          speed_out,
  input logic [FRAC_BITS+1:0] heading_out,
  input logic                 speed_zero
);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_out))
    else $error("result dropped or changed while stalled");

  // the pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // zero speed flag agrees with the speed magnitude
  a_speed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_zero == (speed_out == 32'd0)))
    else $error("speed flag does not match speed");

  // heading is forced to zero for a still target
  a_heading_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_zero |-> (heading_out == '0))
    else $error("heading not zero at zero speed");

endmodule

bind cartesian_to_polar_radar_unit c2p_checker #(.FRAC_BITS(FRAC_BITS)) u_c2p_checker (.*);
